### rtl/ssd_pkg.sv
// Package for the seven-segment scan display: item types, item kinds,
// digit-code constants and the segment decode. No dependencies.
`default_nettype none

package ssd_pkg;

    localparam int NUM_DIGITS_DEF = 6;
    localparam int POS_W          = 3;
    localparam int VALUE_W        = 14;
    localparam int SEG_W          = 8;
    localparam int CODE_W         = 5;
    localparam int TABLE_SIZE     = 21;

    // decimal point is shown by adding this to a digit code
    localparam logic [CODE_W-1:0] DP_OFFSET = 5'd10;

    // floor(v / 10^k) for any 14-bit v, as multiply and shift
    localparam logic [15:0] RECIP10   = 16'd52429;
    localparam int          SHIFT10   = 19;
    localparam logic [12:0] RECIP100  = 13'd5243;
    localparam int          SHIFT100  = 19;
    localparam logic [13:0] RECIP1000 = 14'd8389;
    localparam int          SHIFT1000 = 23;

    localparam logic [VALUE_W-1:0] FMT_XX_X_MIN = 14'd1000;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_VOLT_MEAS = 2'd1,
        KIND_VOLT_SET  = 2'd2,
        KIND_CURRENT   = 2'd3
    } t_kind;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] digit_select;
        logic [SEG_W-1:0] segments;
    } t_out_item;

    // one write of three digit codes into the lower or upper group
    typedef struct packed {
        logic  en;
        logic  upper;
        t_code c0;
        t_code c1;
        t_code c2;
    } t_digit_wr;

    function automatic logic [SEG_W-1:0] seg_pattern(input t_code code);
        logic [SEG_W-1:0] pat;
        unique case (code)
            5'd0:    pat = 8'h3f;
            5'd1:    pat = 8'h06;
            5'd2:    pat = 8'h5b;
            5'd3:    pat = 8'h4f;
            5'd4:    pat = 8'h66;
            5'd5:    pat = 8'h6d;
            5'd6:    pat = 8'h7d;
            5'd7:    pat = 8'h07;
            5'd8:    pat = 8'h7f;
            5'd9:    pat = 8'h6f;
            5'd10:   pat = 8'hbf;
            5'd11:   pat = 8'h86;
            5'd12:   pat = 8'hdb;
            5'd13:   pat = 8'hcf;
            5'd14:   pat = 8'he6;
            5'd15:   pat = 8'hed;
            5'd16:   pat = 8'hfd;
            5'd17:   pat = 8'h87;
            5'd18:   pat = 8'hff;
            5'd19:   pat = 8'hef;
            5'd20:   pat = 8'hf7;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### rtl/ssd_format.sv
// Value formatter: splits a value in hundredths into decimal digits and
// builds the three digit codes for a write item. Depends on ssd_pkg.
`default_nettype none

module ssd_format (
    input  wire logic                        i_en,
    input  wire ssd_pkg::t_kind              i_kind,
    input  wire logic [ssd_pkg::VALUE_W-1:0] i_value,
    output ssd_pkg::t_digit_wr               o_wr
);
    import ssd_pkg::*;

    logic [29:0] p10;
    logic [26:0] p100;
    logic [27:0] p1000;
    logic [10:0] q10;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [13:0] u_full;
    logic [10:0] t_full;
    logic [7:0]  h_full;
    logic [3:0]  dig_u, dig_t, dig_h, dig_th;
    logic [3:0]  rt, rh, rth;
    logic        round_up, carry_t, carry_h;
    logic        is_volt, wide_fmt;

    // three independent reciprocal multiplies
    assign p10   = 30'(i_value) * 30'(RECIP10);
    assign p100  = 27'(i_value) * 27'(RECIP100);
    assign p1000 = 28'(i_value) * 28'(RECIP1000);
    assign q10   = p10[SHIFT10 +: 11];
    assign q100  = p100[SHIFT100 +: 8];
    assign q1000 = p1000[SHIFT1000 +: 5];

    assign u_full = i_value - 14'(q10) * 14'd10;
    assign t_full = q10 - 11'(q100) * 11'd10;
    assign h_full = q100 - 8'(q1000) * 8'd10;
    assign dig_u  = u_full[3:0];
    assign dig_t  = t_full[3:0];
    assign dig_h  = h_full[3:0];
    assign dig_th = (q1000 >= 5'd10) ? 4'(q1000 - 5'd10) : q1000[3:0];

    // rounding adds ten: a BCD increment from the tens digit up
    assign round_up = dig_u > 4'd5;
    assign carry_t  = round_up && (dig_t == 4'd9);
    assign carry_h  = carry_t && (dig_h == 4'd9);
    assign rt  = !round_up ? dig_t  : (carry_t ? 4'd0 : dig_t + 4'd1);
    assign rh  = !carry_t  ? dig_h  : (carry_h ? 4'd0 : dig_h + 4'd1);
    assign rth = !carry_h  ? dig_th : ((dig_th == 4'd9) ? 4'd0 : dig_th + 4'd1);

    assign is_volt  = (i_kind != KIND_CURRENT);
    assign wide_fmt = is_volt && (i_value >= FMT_XX_X_MIN);

    always_comb begin
        o_wr.en    = i_en;
        o_wr.upper = (i_kind != KIND_VOLT_MEAS);
        if (wide_fmt) begin
            o_wr.c0 = {1'b0, rth};
            o_wr.c1 = {1'b0, rh} + DP_OFFSET;
            o_wr.c2 = {1'b0, rt};
        end else begin
            o_wr.c0 = {1'b0, dig_h} + DP_OFFSET;
            o_wr.c1 = {1'b0, dig_t};
            o_wr.c2 = {1'b0, dig_u};
        end
    end

endmodule

`default_nettype wire

### rtl/ssd_scan.sv
// Digit store and scan counter: holds the digit codes, takes digit
// writes and decodes the digit at the scan position. Depends on ssd_pkg.
`default_nettype none

module ssd_scan #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_tick,
    input  wire ssd_pkg::t_digit_wr        i_wr,
    output logic [ssd_pkg::POS_W-1:0]      o_pos,
    output logic [ssd_pkg::SEG_W-1:0]      o_segments
);
    import ssd_pkg::*;

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    t_code            r_codes [NUM_DIGITS];

    assign n_pos = (r_pos == POS_W'(NUM_DIGITS - 1)) ? '0 : r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_tick) begin
            r_pos <= n_pos;
        end
    end

    // digits 0..2 form the lower group, 3..5 the upper one
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (!i_rst_n) begin
                r_codes[i] <= CODE_W'(i + 1);
            end else if (i_wr.en && (i_wr.upper ? (i >= 3 && i < 6) : (i < 3))) begin
                if (i == 0 || i == 3) begin
                    r_codes[i] <= i_wr.c0;
                end else if (i == 1 || i == 4) begin
                    r_codes[i] <= i_wr.c1;
                end else begin
                    r_codes[i] <= i_wr.c2;
                end
            end
        end
    end

    assign o_pos      = r_pos;
    assign o_segments = seg_pattern(r_codes[r_pos[IDX_W-1:0]]);

`ifndef SYNTHESIS
    // one extra bit so that eight digits still compare correctly
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pos} < (POS_W + 1)'(NUM_DIGITS))
        else $error("scan position out of range");

    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick |=> (r_pos == (($past(r_pos) == POS_W'(NUM_DIGITS - 1)) ?
                              POS_W'(0) : $past(r_pos) + POS_W'(1))))
        else $error("scan position did not advance on a tick");

    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_pos))
        else $error("scan position moved without a tick");
`endif

endmodule

`default_nettype wire

### rtl/seven_segment_scan_display.sv
// Six-digit multiplexed seven-segment display driver, top level.
// Path: a scan tick passes the input register, then the output register,
// which holds its result; write items produce no result.
// Throughput: one item per cycle, set by the single input/output register pair, while no tick waits on a full output.
// Reset: scan position 0, digit i holds code i+1, both registers empty.
// Depends on ssd_pkg, ssd_format and ssd_scan.
`default_nettype none

module seven_segment_scan_display #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ssd_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ssd_pkg::t_out_item      o_out_item
);
    import ssd_pkg::*;

    logic             r_s1_valid;
    t_in_item         r_s1;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             in_fire;
    logic             s1_fire;
    logic             s1_tick;
    t_digit_wr        digit_wr;
    logic [POS_W-1:0] scan_pos;
    logic [SEG_W-1:0] scan_seg;

    // a write item always leaves; a tick leaves when the output slot frees
    assign s1_fire    = r_s1_valid &&
                        (r_s1.kind != KIND_TICK || !r_out_valid || i_out_ready);
    assign s1_tick    = s1_fire && (r_s1.kind == KIND_TICK);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_item;
        end
    end

    ssd_format u_format (
        .i_en    (s1_fire && (r_s1.kind != KIND_TICK)),
        .i_kind  (r_s1.kind),
        .i_value (r_s1.value),
        .o_wr    (digit_wr)
    );

    ssd_scan #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (s1_tick),
        .i_wr       (digit_wr),
        .o_pos      (scan_pos),
        .o_segments (scan_seg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_tick) begin
            r_out.digit_select <= scan_pos;
            r_out.segments     <= scan_seg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_out_select_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out.digit_select} < (POS_W + 1)'(NUM_DIGITS)))
        else $error("result selects a digit that does not exist");

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_tick |=> r_out_valid)
        else $error("tick left no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !s1_tick)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
